>>> sv/pnpq_pkg.sv
// per-node priority queue table: shared types, codes and defaults
// no dependencies; imported by every module of the block but pnpq_ram
package pnpq_pkg;

    localparam int NODES_DEF      = 32;
    localparam int PRIORITIES_DEF = 4;
    localparam int DEPTH_DEF      = 16;

    localparam logic [2:0] FN_INSERT = 3'd0;
    localparam logic [2:0] FN_REMOVE = 3'd1;
    localparam logic [2:0] FN_FIND   = 3'd2;
    localparam logic [2:0] FN_READ   = 3'd3;
    localparam logic [2:0] FN_ROUTE  = 3'd4;

    typedef struct packed {
        logic [2:0]  func;
        logic [5:0]  dest_id;
        logic [1:0]  pri;
        logic [3:0]  loc;
        logic        at_head;
        logic        via_route;
        logic [15:0] length;
        logic [31:0] tag;
        logic [5:0]  next_hop;
    } t_in_item;

    typedef struct packed {
        logic        status;
        logic [4:0]  location;
        logic [5:0]  queue_node;
        logic        entry_valid;
        logic [15:0] entry_length;
        logic [31:0] entry_tag;
    } t_out_item;

    typedef struct packed {
        logic        valid;
        logic [15:0] length;
        logic [31:0] tag;
    } t_slot;

    typedef enum logic [2:0] {
        K_DONE, K_PUT, K_HEAD, K_REM, K_FIND, K_GET
    } t_kind;

    typedef enum logic [1:0] {
        RS_IDX, RS_DEC, RS_INC
    } t_rsel;

    typedef enum logic [1:0] {
        WS_NEW, WS_RD, WS_CUR, WS_ZERO
    } t_wsel;

    typedef enum logic [1:0] {
        IX_HOLD, IX_INC, IX_DEC
    } t_idxop;

    typedef enum logic [3:0] {
        ST_CLEAR, ST_IDLE, ST_BASE, ST_SHIFT_RD, ST_SHIFT_WR, ST_PUT,
        ST_REM_RD, ST_REM_CUR, ST_REM_NEXT, ST_REM_CHK, ST_REM_END,
        ST_FIND_RD, ST_FIND_CHK, ST_GET_RD, ST_GET_CHK, ST_RESULT
    } t_state;

    typedef struct packed {
        logic   load;
        logic   base;
        logic   clr;
        logic   rd;
        t_rsel  rsel;
        logic   wr;
        t_wsel  wsel;
        t_idxop idx_op;
        logic   cur_load;
        logic   entry_load;
        logic   res;
    } t_cmd;

    typedef struct packed {
        t_kind kind;
        logic  idx_zero;
        logic  idx_one;
        logic  idx_last;
        logic  idx_end;
        logic  rd_valid;
        logic  clr_last;
        logic  out_free;
    } t_stat;

endpackage

>>> sv/pnpq_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies
module pnpq_ram #(
    parameter int W = 8,
    parameter int D = 16
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [$clog2(D)-1:0] i_waddr,
    input  logic [W-1:0]         i_wdata,
    input  logic                 i_re,
    input  logic [$clog2(D)-1:0] i_raddr,
    output logic [W-1:0]         o_rdata
);

    logic [W-1:0] r_mem [D];
    logic [W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> sv/pnpq_dp.sv
// datapath: item registers, slot index, route table, queue store and result register
// depends on pnpq_pkg and pnpq_ram
module pnpq_dp import pnpq_pkg::*; #(
    parameter int NODES      = NODES_DEF,
    parameter int PRIORITIES = PRIORITIES_DEF,
    parameter int DEPTH      = DEPTH_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cmd      i_cmd,
    output t_stat     o_stat,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    output t_out_item o_out_item,
    input  logic      i_out_stall
);

    localparam int NSLOT = NODES * PRIORITIES * DEPTH;
    localparam int AW    = $clog2(NSLOT);
    localparam int CW    = $clog2(DEPTH + 1);
    localparam int NW    = $clog2(NODES);

    logic [5:0]    r_route [NODES];
    t_kind         r_kind;
    logic [5:0]    r_node;
    logic [1:0]    r_pri;
    logic [CW-1:0] r_idx;
    logic [AW-1:0] r_base;
    logic [AW-1:0] r_clr;
    logic [15:0]   r_len;
    logic [31:0]   r_tag;
    logic          r_status;
    logic [5:0]    r_qnode;
    logic          r_is_find;
    t_slot         r_cur;
    t_slot         r_entry;
    logic          r_out_valid;
    t_out_item     r_out;

    t_kind         n_kind;
    logic [5:0]    n_node;
    logic [CW-1:0] n_idx;
    logic          n_status;
    logic [5:0]    n_qnode;

    logic          dest_ok, pri_ok, loc_ok, ins_ok;
    logic [5:0]    hop, ins_node;
    logic [NW-1:0] dest_idx;
    logic [CW-1:0] rslot;
    logic          we;
    logic [AW-1:0] waddr, raddr;
    t_slot         wdata, rdata;
    logic [$bits(t_slot)-1:0] w_rdata;

    always_comb begin
        dest_idx = NW'(i_in_item.dest_id - 6'd1);
        dest_ok  = (i_in_item.dest_id != 6'd0) && (32'(i_in_item.dest_id) <= NODES);
        pri_ok   = 32'(i_in_item.pri) < PRIORITIES;
        loc_ok   = 32'(i_in_item.loc) < DEPTH;
        hop      = dest_ok ? r_route[dest_idx] : 6'd0;
        ins_node = i_in_item.via_route ? hop : i_in_item.dest_id;
        ins_ok   = pri_ok && (ins_node != 6'd0) && (32'(ins_node) <= NODES)
                   && (i_in_item.at_head || loc_ok);
    end

    always_comb begin
        n_node   = i_in_item.dest_id;
        n_kind   = K_DONE;
        n_idx    = CW'(i_in_item.loc);
        n_status = 1'b0;
        n_qnode  = 6'd0;
        unique case (i_in_item.func)
            FN_INSERT: begin
                n_node = ins_node;
                if (!ins_ok) begin
                    n_status = 1'b1;
                end else begin
                    n_qnode = ins_node;
                    if (i_in_item.at_head) begin
                        n_kind = K_HEAD;
                        if (!loc_ok) begin
                            n_idx = CW'(DEPTH - 1);
                        end
                    end else begin
                        n_kind = K_PUT;
                    end
                end
            end
            FN_REMOVE: begin
                if (dest_ok && pri_ok && loc_ok) begin
                    n_kind = K_REM;
                end
            end
            FN_FIND: begin
                if (dest_ok && pri_ok) begin
                    n_kind = K_FIND;
                    n_idx  = '0;
                end else begin
                    n_idx  = CW'(DEPTH);
                end
            end
            FN_READ: begin
                if (dest_ok && pri_ok && loc_ok) begin
                    n_kind = K_GET;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NODES; i++) begin
                r_route[i] <= 6'd0;
            end
        end else if (i_cmd.load && i_in_item.func == FN_ROUTE && dest_ok) begin
            r_route[dest_idx] <= i_in_item.next_hop;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_len     <= i_in_item.length;
            r_tag     <= i_in_item.tag;
            r_pri     <= i_in_item.pri;
            r_is_find <= i_in_item.func == FN_FIND;
            r_entry   <= '0;
            r_status  <= n_status;
            r_qnode   <= n_qnode;
            r_node    <= n_node;
            r_kind    <= n_kind;
            r_idx     <= n_idx;
        end else begin
            unique case (i_cmd.idx_op)
                IX_INC:  r_idx <= r_idx + CW'(1);
                IX_DEC:  r_idx <= r_idx - CW'(1);
                default: r_idx <= r_idx;
            endcase
            if (i_cmd.base) begin
                r_base <= AW'(((32'(r_node) - 1) * PRIORITIES + 32'(r_pri)) * DEPTH);
            end
            if (i_cmd.cur_load) begin
                r_cur <= rdata;
            end
            if (i_cmd.entry_load) begin
                r_entry <= rdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr <= '0;
        end else if (i_cmd.clr) begin
            r_clr <= r_clr + AW'(1);
        end
    end

    always_comb begin
        unique case (i_cmd.rsel)
            RS_DEC:  rslot = r_idx - CW'(1);
            RS_INC:  rslot = r_idx + CW'(1);
            default: rslot = r_idx;
        endcase
        raddr = r_base + AW'(rslot);
        waddr = i_cmd.clr ? r_clr : r_base + AW'(r_idx);
        we    = i_cmd.wr || i_cmd.clr;
        unique case (i_cmd.wsel)
            WS_NEW:  wdata = {1'b1, r_len, r_tag};
            WS_RD:   wdata = rdata;
            WS_CUR:  wdata = {1'b0, r_cur.length, r_cur.tag};
            default: wdata = '0;
        endcase
    end

    pnpq_ram #(
        .W($bits(t_slot)),
        .D(NSLOT)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_re    (i_cmd.rd),
        .i_raddr (raddr),
        .o_rdata (w_rdata)
    );

    assign rdata = t_slot'(w_rdata);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.res) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.res) begin
            r_out.status       <= r_status;
            r_out.location     <= r_is_find ? 5'(r_idx) : 5'd0;
            r_out.queue_node   <= r_qnode;
            r_out.entry_valid  <= r_entry.valid;
            r_out.entry_length <= r_entry.length;
            r_out.entry_tag    <= r_entry.tag;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    always_comb begin
        o_stat.kind     = r_kind;
        o_stat.idx_zero = r_idx == CW'(0);
        o_stat.idx_one  = r_idx == CW'(1);
        o_stat.idx_last = r_idx == CW'(DEPTH - 1);
        o_stat.idx_end  = r_idx == CW'(DEPTH);
        o_stat.rd_valid = rdata.valid;
        o_stat.clr_last = r_clr == AW'(NSLOT - 1);
        o_stat.out_free = !r_out_valid || !i_out_stall;
    end

endmodule

>>> sv/pnpq_ctrl.sv
// controller: state machine sequencing store clearing, shifts, searches and results
// depends on pnpq_pkg
module pnpq_ctrl import pnpq_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_stall,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR:    if (i_stat.clr_last) n_state = ST_IDLE;
            ST_IDLE:     if (i_in_valid) n_state = ST_BASE;
            ST_BASE: begin
                unique case (i_stat.kind)
                    K_HEAD:  n_state = i_stat.idx_zero ? ST_PUT : ST_SHIFT_RD;
                    K_PUT:   n_state = ST_PUT;
                    K_REM:   n_state = ST_REM_RD;
                    K_FIND:  n_state = ST_FIND_RD;
                    K_GET:   n_state = ST_GET_RD;
                    default: n_state = ST_RESULT;
                endcase
            end
            ST_SHIFT_RD: n_state = ST_SHIFT_WR;
            ST_SHIFT_WR: n_state = i_stat.idx_one ? ST_PUT : ST_SHIFT_RD;
            ST_PUT:      n_state = ST_RESULT;
            ST_REM_RD:   n_state = ST_REM_CUR;
            ST_REM_CUR:  n_state = ST_REM_NEXT;
            ST_REM_NEXT: n_state = i_stat.idx_last ? ST_REM_END : ST_REM_CHK;
            ST_REM_CHK:  n_state = i_stat.rd_valid ? ST_REM_NEXT : ST_REM_END;
            ST_REM_END:  n_state = ST_RESULT;
            ST_FIND_RD:  n_state = i_stat.idx_end ? ST_RESULT : ST_FIND_CHK;
            ST_FIND_CHK: n_state = i_stat.rd_valid ? ST_FIND_RD : ST_RESULT;
            ST_GET_RD:   n_state = ST_GET_CHK;
            ST_GET_CHK:  n_state = ST_RESULT;
            ST_RESULT:   if (i_stat.out_free) n_state = ST_IDLE;
            default:     n_state = ST_CLEAR;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_cmd.rsel = RS_IDX;
        o_cmd.wsel = WS_ZERO;
        o_cmd.idx_op = IX_HOLD;
        o_in_stall = r_state != ST_IDLE;
        unique case (r_state)
            ST_CLEAR:    o_cmd.clr = 1'b1;
            ST_IDLE:     o_cmd.load = i_in_valid;
            ST_BASE:     o_cmd.base = 1'b1;
            ST_SHIFT_RD: begin
                o_cmd.rd   = 1'b1;
                o_cmd.rsel = RS_DEC;
            end
            ST_SHIFT_WR: begin
                o_cmd.wr     = 1'b1;
                o_cmd.wsel   = WS_RD;
                o_cmd.idx_op = IX_DEC;
            end
            ST_PUT: begin
                o_cmd.wr   = 1'b1;
                o_cmd.wsel = WS_NEW;
            end
            ST_REM_RD:   o_cmd.rd = 1'b1;
            ST_REM_CUR:  o_cmd.cur_load = 1'b1;
            ST_REM_NEXT: begin
                o_cmd.rd   = !i_stat.idx_last;
                o_cmd.rsel = RS_INC;
            end
            ST_REM_CHK: begin
                if (i_stat.rd_valid) begin
                    o_cmd.wr       = 1'b1;
                    o_cmd.wsel     = WS_RD;
                    o_cmd.cur_load = 1'b1;
                    o_cmd.idx_op   = IX_INC;
                end
            end
            ST_REM_END: begin
                o_cmd.wr   = 1'b1;
                o_cmd.wsel = WS_CUR;
            end
            ST_FIND_RD:  o_cmd.rd = !i_stat.idx_end;
            ST_FIND_CHK: if (i_stat.rd_valid) o_cmd.idx_op = IX_INC;
            ST_GET_RD:   o_cmd.rd = 1'b1;
            ST_GET_CHK:  o_cmd.entry_load = 1'b1;
            ST_RESULT:   o_cmd.res = i_stat.out_free;
            default: begin
            end
        endcase
    end

endmodule

>>> sv/per_node_priority_queue_table_top.sv
// Per-node priority queue table. One item is taken at a time. A head insert steps
// once per slot from loc down to the head, a remove once per entry it moves, and a
// find empty once per slot until it finds a free slot or reaches the queue's end;
// each step of a head insert or a remove is a read and a write, and each step of a
// find a read, through the single queue store ram with its registered read. After
// reset all NODES*PRIORITIES*DEPTH slots of the store (2048 by default) are swept
// clear before the first item is taken. A finished result waits in an output
// register; the next item is taken only after that register has accepted the
// result.
// depends on pnpq_pkg, pnpq_ctrl, pnpq_dp
module per_node_priority_queue_table_top import pnpq_pkg::*; #(
    parameter int NODES      = NODES_DEF,
    parameter int PRIORITIES = PRIORITIES_DEF,
    parameter int DEPTH      = DEPTH_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  t_in_item  i_in_item,
    output logic      o_in_stall,
    output logic      o_out_valid,
    output t_out_item o_out_item,
    input  logic      i_out_stall
);

    t_cmd  w_cmd;
    t_stat w_stat;

    pnpq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    pnpq_dp #(
        .NODES      (NODES),
        .PRIORITIES (PRIORITIES),
        .DEPTH      (DEPTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item),
        .i_out_stall (i_out_stall)
    );

endmodule

>>> sv/pnpq_chk.sv
// port-level checker for the queue table top level, with its bind
// depends on pnpq_pkg
module pnpq_chk import pnpq_pkg::*; (
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input t_in_item  i_in_item,
    input logic      o_in_stall,
    input logic      o_out_valid,
    input t_out_item o_out_item,
    input logic      i_out_stall
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_item))
        else $error("stalled result item dropped or changed");

    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> o_in_stall && !o_out_valid)
        else $error("item taken or result shown during store clearing");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("second item taken before the first finished");

    a_drop_no_node: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_out_item.status && o_out_item.queue_node != 6'd0))
        else $error("dropped insert reports a written queue");

endmodule

bind per_node_priority_queue_table_top pnpq_chk u_chk (.*);
